// ===== hw/rtl/afir_pkg.sv =====
// Shared types, sizes and the coefficient table of the accelerometer FIR filter.
// Used by every module of the filter; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package afir_pkg;

    localparam int TAP_COUNT   = 21;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int FRAC_BITS   = COEF_BITS - 1;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS    = PROD_BITS + $clog2(TAP_COUNT + 1);
    localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;

    localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_BITS - 1);
    localparam acc_t SAMPLE_MAX = acc_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam acc_t SAMPLE_MIN = -SAMPLE_MAX - acc_t'(1);

    // Q1.15 taps of the high-pass filter; taps past the table are zero.
    function automatic coef_t tap_coef(input int k);
        coef_t c;
        case (k)
            0, 20:   c = coef_t'(-534);
            1, 19:   c = coef_t'(-2324);
            2, 18:   c = coef_t'(740);
            3, 17:   c = coef_t'(1217);
            4, 16:   c = coef_t'(-440);
            5, 15:   c = coef_t'(-1933);
            6, 14:   c = coef_t'(475);
            7, 13:   c = coef_t'(3382);
            8, 12:   c = coef_t'(-488);
            9, 11:   c = coef_t'(-10399);
            10:      c = coef_t'(16876);
            default: c = coef_t'(0);
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/accel_fir_filter_top.sv =====
// Top level of the 21-tap accelerometer FIR filter: a transposed chain of
// afir_cell instances feeding the afir_out head stage. Depends on afir_pkg.
//
// Usage:
// The slave channel takes one signed 16-bit Z sample per item on
// s_axis_tdata. The master channel returns one filtered sample per item on
// m_axis_tdata, with m_axis_tuser set when the value was clipped to range.
// Each accepted item advances the whole chain of partial sums by one step,
// so the history lives in the cells and no separate delay line exists.
// The result of an item is valid on the cycle after it is accepted.
// Throughput is one item per cycle while the receiver keeps up, set by the
// single output register that every item passes through.
// The block takes a new item whenever the output register is empty or is
// being read in the same cycle; while the receiver stalls a full output
// register, s_axis_tready is low and the chain holds still.
// Reset clears all partial sums, which equals an all-zero sample history,
// and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module accel_fir_filter_top
    import afir_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [TDATA_BITS-1:0] s_axis_tdata,  // [15:0] raw_sample
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [TDATA_BITS-1:0]      m_axis_tdata,  // [15:0] filtered_sample
    output logic                       m_axis_tuser   // [0] saturated
);

    logic    advance;
    logic    taken;
    sample_t sample;
    sample_t result;
    acc_t    chain [TAP_COUNT+1];

    assign sample        = sample_t'(s_axis_tdata[SAMPLE_BITS-1:0]);
    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign advance       = s_axis_tvalid && s_axis_tready;
    assign taken         = m_axis_tvalid && m_axis_tready;
    assign chain[TAP_COUNT] = '0;
    assign chain[0]         = '0;

    for (genvar k = 1; k < TAP_COUNT; k++)
    begin : g_cell
        afir_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .sample  (sample),
            .coef    (tap_coef(k)),
            .sum_in  (chain[k+1]),
            .sum_out (chain[k])
        );
    end

    afir_out u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .taken   (taken),
        .sample  (sample),
        .sum_in  ((TAP_COUNT > 1) ? chain[1] : chain[0]),
        .valid   (m_axis_tvalid),
        .result  (result),
        .clipped (m_axis_tuser)
    );

    assign m_axis_tdata = TDATA_BITS'({{(TDATA_BITS-SAMPLE_BITS){1'b0}}, result});

`ifndef SYNTHESIS
    // An accepted item always shows up as a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted item did not produce a result");

    // A result only appears after an item was accepted or while one is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready)
        |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("result appeared without an accepted item");

    // A clipped result sits exactly at one of the range limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser
        |-> result == sample_t'(SAMPLE_MAX) || result == sample_t'(SAMPLE_MIN))
        else $error("saturated flag set on an unclipped value");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/afir_cell.sv =====
// One cell of the transposed FIR chain: multiplies the incoming sample by its
// tap and adds the partial sum of its right neighbor. Depends on afir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afir_cell
    import afir_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  wire sample_t sample,
    input  wire coef_t   coef,
    input  wire acc_t    sum_in,
    output acc_t         sum_out
);

    prod_t prod;
    acc_t  sum_reg;
    acc_t  sum_next;

    always_comb
    begin
        prod     = prod_t'(sample) * prod_t'(coef);
        sum_next = acc_t'(prod) + sum_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (advance)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/afir_out.sv =====
// Head of the chain: applies the first tap, rounds, saturates and holds the
// result in the output register until it is taken. Depends on afir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afir_out
    import afir_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  wire logic    taken,
    input  wire sample_t sample,
    input  wire acc_t    sum_in,
    output logic         valid,
    output sample_t      result,
    output logic         clipped
);

    prod_t   prod;
    acc_t    total;
    acc_t    scaled;
    sample_t result_next;
    logic    clipped_next;
    logic    valid_reg;
    logic    valid_next;
    sample_t result_reg;
    logic    clipped_reg;

    always_comb
    begin
        prod   = prod_t'(sample) * prod_t'(tap_coef(0));
        total  = acc_t'(prod) + sum_in + ROUND_HALF;
        scaled = total >>> FRAC_BITS;
        if (scaled > SAMPLE_MAX)
        begin
            result_next  = sample_t'(SAMPLE_MAX);
            clipped_next = 1'b1;
        end
        else if (scaled < SAMPLE_MIN)
        begin
            result_next  = sample_t'(SAMPLE_MIN);
            clipped_next = 1'b1;
        end
        else
        begin
            result_next  = sample_t'(scaled);
            clipped_next = 1'b0;
        end
    end

    always_comb
    begin
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (taken)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg  <= result_next;
            clipped_reg <= clipped_next;
        end
    end

    assign valid   = valid_reg;
    assign result  = result_reg;
    assign clipped = clipped_reg;

endmodule

`default_nettype wire
